/* rtl/core/pdprg_pkg.sv */
`timescale 1ns / 1ps

package pdprg_pkg;

    localparam int unsigned PTR_W = 17;
    localparam int unsigned LEN_OUT_W = 9;

    localparam logic [PTR_W-1:0] PTR_MAX = 17'h1FFFF;

    localparam logic [15:0] ADDR_DATA = 16'hFEF0;
    localparam logic [15:0] ADDR_STATUS = 16'hFEF1;
    localparam logic [15:0] ADDR_HANDSHAKE = 16'hFEF2;

    localparam logic [2:0] KIND_BUS_READ = 3'd0;
    localparam logic [2:0] KIND_BUS_WRITE = 3'd1;
    localparam logic [2:0] KIND_LOAD_RESP = 3'd2;
    localparam logic [2:0] KIND_SET_STATUS = 3'd3;
    localparam logic [2:0] KIND_READ_CMD = 3'd4;

    localparam logic [7:0] CMD_INIT = 8'h55;
    localparam logic [7:0] CMD_DEVID = 8'h81;
    localparam logic [7:0] CMD_ACK = 8'h82;
    localparam logic [7:0] CMD_DATA_IN = 8'h83;
    localparam logic [7:0] CMD_READ_BYTE = 8'h84;
    localparam logic [7:0] CMD_E0 = 8'hE0;
    localparam logic [7:0] CMD_E1 = 8'hE1;
    localparam logic [7:0] CMD_F0 = 8'hF0;
    localparam logic [7:0] CMD_F1 = 8'hF1;

    localparam logic [7:0] ID_TALK = 8'h20;
    localparam logic [7:0] ID_LISTEN = 8'h40;
    localparam logic [7:0] ID_UNTALK = 8'h3F;
    localparam logic [7:0] ID_UNLISTEN = 8'h5F;

    localparam logic [7:0] HS_SET = 8'h00;
    localparam logic [7:0] HS_CLEAR = 8'h40;
    localparam logic [7:0] HS_ONES = 8'hFF;

    localparam logic [7:0] STATUS_OK = 8'h00;
    localparam logic [7:0] STATUS_EOF = 8'h03;

    localparam logic [1:0] CFG_DRIVE_ENABLED = 2'd0;

    typedef enum logic [1:0] {
        LINK_IDLE  = 2'd0,
        LINK_DEVID = 2'd1,
        LINK_INPUT = 2'd2
    } t_link;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_EXEC = 1'b1
    } t_phase;

endpackage

/* rtl/core/parallel_drive_port_regs_core.sv */
`timescale 1ns / 1ps
// Accepting start enters the execute phase, from which the result is registered onto o_done.
// No new item is accepted while busy; each item reads a store in its accept cycle and
// writes it back in the following cycle through the same single memory port.
// The receiver cannot stall; each result is presented for exactly one cycle.
// Reset (synchronous, active low) clears link, bus registers, counters and enables the drive;
// the command and response stores are not cleared and hold undefined data until written.

module parallel_drive_port_regs_core #(
    parameter int unsigned CMD_DEPTH = 256,
    parameter int unsigned RESP_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_buffer_index,
    input  logic [7:0]  i_buffer_byte,
    input  logic        i_buffer_last,
    input  logic [7:0]  i_status_value,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic        o_command_ready,
    output logic [8:0]  o_command_length
);
    import pdprg_pkg::*;

    logic r_drive_enabled, n_drive_enabled;

    assign pready = 1'b1;

    always_comb begin
        n_drive_enabled = r_drive_enabled;
        if (psel && penable && pwrite && paddr == CFG_DRIVE_ENABLED) begin
            n_drive_enabled = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_enabled <= 1'b1;
        end else begin
            r_drive_enabled <= n_drive_enabled;
        end
    end

    assign prdata = (paddr == CFG_DRIVE_ENABLED) ? {31'd0, r_drive_enabled} : 32'd0;

    pdprg_engine #(
        .CMD_DEPTH (CMD_DEPTH),
        .RESP_DEPTH(RESP_DEPTH)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_enabled       (r_drive_enabled),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_bus_address   (i_bus_address),
        .i_write_data    (i_write_data),
        .i_buffer_index  (i_buffer_index),
        .i_buffer_byte   (i_buffer_byte),
        .i_buffer_last   (i_buffer_last),
        .i_status_value  (i_status_value),
        .o_done          (o_done),
        .o_read_data     (o_read_data),
        .o_command_ready (o_command_ready),
        .o_command_length(o_command_length)
    );

endmodule

/* rtl/core/pdprg_ram.sv */
`timescale 1ns / 1ps

module pdprg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pdprg_engine.sv */
`timescale 1ns / 1ps

module pdprg_engine #(
    parameter int unsigned CMD_DEPTH = 256,
    parameter int unsigned RESP_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enabled,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_buffer_index,
    input  logic [7:0]  i_buffer_byte,
    input  logic        i_buffer_last,
    input  logic [7:0]  i_status_value,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic        o_command_ready,
    output logic [8:0]  o_command_length
);
    import pdprg_pkg::*;

    localparam int unsigned CAW = $clog2(CMD_DEPTH);
    localparam int unsigned CW = $clog2(CMD_DEPTH + 1);
    localparam int unsigned RAW = $clog2(RESP_DEPTH);
    localparam logic [PTR_W-1:0] CMD_LIMIT = PTR_W'(CMD_DEPTH);
    localparam logic [PTR_W-1:0] RESP_LIMIT = PTR_W'(RESP_DEPTH);

    t_phase r_phase, n_phase;
    t_link  r_link, n_link;
    logic [7:0]       r_data, n_data;
    logic [7:0]       r_status, n_status;
    logic [7:0]       r_hs, n_hs;
    logic [CW-1:0]    r_cmd_count, n_cmd_count;
    logic [PTR_W-1:0] r_resp_ptr, n_resp_ptr;
    logic [PTR_W-1:0] r_resp_len, n_resp_len;

    logic [2:0]  r_kind;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [15:0] r_idx;
    logic [7:0]  r_bbyte;
    logic        r_blast;
    logic [7:0]  r_sval;

    logic       r_done, n_done;
    logic [7:0] r_rd, n_rd;
    logic       r_ready, n_ready;
    logic [8:0] r_len_out, n_len_out;

    logic             accept;
    logic             cmd_we;
    logic [CAW-1:0]   cmd_addr;
    logic [7:0]       cmd_rdata;
    logic             resp_we;
    logic [RAW-1:0]   resp_addr;
    logic [7:0]       resp_rdata;
    logic [PTR_W-1:0] idx_ext;
    logic [PTR_W-1:0] cnt_ext;
    logic [PTR_W-1:0] ptr_inc;

    assign accept = start && (r_phase == PH_IDLE);
    assign busy = (r_phase == PH_EXEC);
    assign idx_ext = {1'b0, r_idx};
    assign cnt_ext = PTR_W'(r_cmd_count);
    assign ptr_inc = (r_resp_ptr < PTR_MAX) ? (r_resp_ptr + PTR_W'(1)) : r_resp_ptr;

    // Stores are read in the accept cycle and written in the execute cycle.
    assign cmd_addr = (r_phase == PH_IDLE) ? i_buffer_index[CAW-1:0] : r_cmd_count[CAW-1:0];
    assign resp_addr = (r_phase == PH_IDLE) ? r_resp_ptr[RAW-1:0] : r_idx[RAW-1:0];

    pdprg_ram #(
        .WIDTH(8),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_ram (
        .i_clk  (i_clk),
        .i_we   (cmd_we),
        .i_addr (cmd_addr),
        .i_wdata(r_wdata),
        .o_rdata(cmd_rdata)
    );

    pdprg_ram #(
        .WIDTH(8),
        .DEPTH(RESP_DEPTH)
    ) u_resp_ram (
        .i_clk  (i_clk),
        .i_we   (resp_we),
        .i_addr (resp_addr),
        .i_wdata(r_bbyte),
        .o_rdata(resp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_link <= LINK_IDLE;
            r_data <= '0;
            r_status <= '0;
            r_hs <= '0;
            r_cmd_count <= '0;
            r_resp_ptr <= '0;
            r_resp_len <= '0;
            r_done <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_link <= n_link;
            r_data <= n_data;
            r_status <= n_status;
            r_hs <= n_hs;
            r_cmd_count <= n_cmd_count;
            r_resp_ptr <= n_resp_ptr;
            r_resp_len <= n_resp_len;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_addr <= i_bus_address;
            r_wdata <= i_write_data;
            r_idx <= i_buffer_index;
            r_bbyte <= i_buffer_byte;
            r_blast <= i_buffer_last;
            r_sval <= i_status_value;
        end
        r_rd <= n_rd;
        r_ready <= n_ready;
        r_len_out <= n_len_out;
    end

    always_comb begin
        n_phase = r_phase;
        n_link = r_link;
        n_data = r_data;
        n_status = r_status;
        n_hs = r_hs;
        n_cmd_count = r_cmd_count;
        n_resp_ptr = r_resp_ptr;
        n_resp_len = r_resp_len;
        n_done = 1'b0;
        n_rd = r_rd;
        n_ready = r_ready;
        n_len_out = r_len_out;
        cmd_we = 1'b0;
        resp_we = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (accept) begin
                    n_phase = PH_EXEC;
                end
            end
            PH_EXEC: begin
                n_phase = PH_IDLE;
                n_done = 1'b1;
                n_rd = '0;
                n_ready = 1'b0;
                unique case (r_kind)
                    KIND_BUS_READ: begin
                        if (i_enabled) begin
                            if (r_addr == ADDR_DATA) begin
                                n_rd = r_data;
                            end else if (r_addr == ADDR_STATUS) begin
                                n_rd = r_status;
                            end else if (r_addr == ADDR_HANDSHAKE) begin
                                n_rd = r_hs;
                            end
                        end
                    end
                    KIND_BUS_WRITE: begin
                        if (i_enabled && r_addr == ADDR_DATA) begin
                            unique case (r_link)
                                LINK_DEVID: begin
                                    unique case (r_wdata)
                                        ID_TALK: begin
                                            n_hs = HS_ONES;
                                            n_cmd_count = '0;
                                            n_link = LINK_IDLE;
                                        end
                                        ID_LISTEN: begin
                                            n_hs = HS_ONES;
                                            n_resp_ptr = '0;
                                            n_link = LINK_IDLE;
                                        end
                                        ID_UNTALK: begin
                                            if (r_cmd_count == '0) begin
                                                n_resp_ptr = '0;
                                                n_resp_len = '0;
                                            end else begin
                                                n_ready = 1'b1;
                                            end
                                            n_hs = HS_ONES;
                                            n_link = LINK_IDLE;
                                        end
                                        ID_UNLISTEN: begin
                                            n_hs = HS_ONES;
                                            n_status = STATUS_OK;
                                            n_link = LINK_IDLE;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                                LINK_INPUT: begin
                                    if (cnt_ext < CMD_LIMIT) begin
                                        cmd_we = 1'b1;
                                        n_cmd_count = r_cmd_count + CW'(1);
                                    end
                                    n_link = LINK_IDLE;
                                end
                                LINK_IDLE: begin
                                    unique case (r_wdata)
                                        CMD_INIT: begin
                                            n_data = CMD_INIT;
                                            n_status = STATUS_OK;
                                            n_cmd_count = '0;
                                        end
                                        CMD_DEVID: begin
                                            n_hs = '0;
                                            n_link = LINK_DEVID;
                                        end
                                        CMD_ACK: begin
                                            n_hs = '0;
                                        end
                                        CMD_DATA_IN: begin
                                            n_hs = '0;
                                            n_link = LINK_INPUT;
                                        end
                                        CMD_READ_BYTE: begin
                                            if (r_resp_ptr < r_resp_len
                                                    && r_resp_ptr < RESP_LIMIT) begin
                                                n_data = resp_rdata;
                                            end else begin
                                                n_data = '0;
                                            end
                                            n_resp_ptr = ptr_inc;
                                            n_hs = '0;
                                            n_status = (ptr_inc == r_resp_len) ?
                                                       STATUS_EOF : STATUS_OK;
                                        end
                                        CMD_E0, CMD_E1: begin
                                            n_status = STATUS_OK;
                                            n_hs = HS_ONES;
                                        end
                                        CMD_F0, CMD_F1: begin
                                            n_hs = HS_ONES;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                                default: begin
                                end
                            endcase
                        end else if (i_enabled && r_addr == ADDR_HANDSHAKE) begin
                            if (r_wdata == HS_SET) begin
                                n_hs = HS_ONES;
                            end else if (r_wdata == HS_CLEAR) begin
                                n_hs = '0;
                            end
                        end
                    end
                    KIND_LOAD_RESP: begin
                        if (idx_ext < RESP_LIMIT) begin
                            resp_we = 1'b1;
                            if (r_blast) begin
                                n_resp_len = idx_ext + PTR_W'(1);
                            end
                        end
                    end
                    KIND_SET_STATUS: begin
                        n_status = r_sval;
                    end
                    KIND_READ_CMD: begin
                        if (idx_ext < cnt_ext && idx_ext < CMD_LIMIT) begin
                            n_rd = cmd_rdata;
                        end
                    end
                    default: begin
                    end
                endcase
                n_len_out = LEN_OUT_W'(n_cmd_count);
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_read_data = r_rd;
    assign o_command_ready = r_ready;
    assign o_command_length = r_len_out;

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_phase == PH_EXEC))
        else $error("Result transfer without an executed item.");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= CMD_LIMIT)
        else $error("Command count exceeds the store capacity.");

    a_ready_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_ready) |-> (r_len_out != '0 || CW > LEN_OUT_W))
        else $error("Command ready reported with an empty command store.");

    a_cmd_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_we |-> (cnt_ext < CMD_LIMIT && r_phase == PH_EXEC))
        else $error("Command store written while full or outside execution.");

endmodule
